@@ hdl/checked_block_deframer_top_assert.svh @@
// Assertion macros shared by the checked block deframer RTL.
// Included by the top level; depends on nothing else.
`ifndef CHECKED_BLOCK_DEFRAMER_TOP_ASSERT_SVH
`define CHECKED_BLOCK_DEFRAMER_TOP_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define CBD_ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error(msg);

// Condition a implies condition b in the next cycle.
`define CBD_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error(msg);

`endif

@@ hdl/cbd_pkg.sv @@
// Package for the checked block deframer: result type, status codes, constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cbd_pkg;

    // Width of the block length register.
    localparam int unsigned CFG_W = 11;
    // Block length after reset.
    localparam logic [CFG_W-1:0] BLOCK_LEN_RESET = 11'd1000;
    // Shortest block: the header plus one word.
    localparam int unsigned MIN_BLOCK_BYTES = 6;
    // Header bytes: checksum word and length word.
    localparam int unsigned HEADER_BYTES = 4;
    // Payload length field of the length word, and the final block flag bit.
    localparam int unsigned LEN_FIELD_W = 12;
    localparam int unsigned FINAL_FLAG_BIT = 15;

    // Register byte addresses.
    localparam logic [2:0] ADDR_BLOCK_LENGTH = 3'd0;

    // Block status codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_LEN  = 2'd1,
        STATUS_MISMATCH = 2'd2,
        STATUS_PARTIAL  = 2'd3
    } status_t;

    // Run state of the deframer.
    typedef enum logic [2:0] {
        MODE_ACTIVE   = 3'b001,
        MODE_FINISHED = 3'b010,
        MODE_FAILED   = 3'b100
    } mode_t;

    // One result item.
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       block_done;
        status_t    block_status;
        logic       final_block;
    } result_t;

    // Status of the core seen by the top level.
    typedef struct packed {
        logic active;
        logic result_valid;
    } core_status_t;

endpackage

`default_nettype wire

@@ hdl/cbd_apb_regs.sv @@
// APB register file of the checked block deframer: the block length register.
// Depends on cbd_pkg.
`default_nettype none

module cbd_apb_regs (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [2:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output logic      [cbd_pkg::CFG_W-1:0] block_length
);

    logic [cbd_pkg::CFG_W-1:0] block_length_reg;
    logic                      sel_length;
    logic                      wr_en;

    assign pready     = 1'b1;
    assign sel_length = (paddr[2] == cbd_pkg::ADDR_BLOCK_LENGTH[2]);
    assign wr_en      = psel && penable && pwrite && pready;

    // Write in the access cycle; addresses 0 to 3 alias, 4 to 7 are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_length_reg <= cbd_pkg::BLOCK_LEN_RESET;
        end else if (wr_en && sel_length) begin
            block_length_reg <= pwdata[cbd_pkg::CFG_W-1:0];
        end
    end

    // Read data.
    always_comb begin
        prdata = 32'd0;
        if (sel_length) begin
            prdata = {{(32-cbd_pkg::CFG_W){1'b0}}, block_length_reg};
        end
    end

    assign block_length = block_length_reg;

endmodule

`default_nettype wire

@@ hdl/cbd_core.sv @@
// Per-byte deframing logic: header capture, running checksum, block close.
// Depends on cbd_pkg.
`default_nettype none

module cbd_core #(
    parameter int unsigned MAX_BLOCK_BYTES = 1024
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      accept,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      end_of_input,
    input  wire logic [cbd_pkg::CFG_W-1:0] block_length,
    output cbd_pkg::result_t               result,
    output cbd_pkg::core_status_t          status
);

    localparam int unsigned LEN_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int unsigned POS_W = $clog2(MAX_BLOCK_BYTES);
    localparam int unsigned CMP_W = (LEN_W > cbd_pkg::CFG_W) ? LEN_W : cbd_pkg::CFG_W;
    localparam int unsigned WIDE_W =
        (CMP_W > cbd_pkg::LEN_FIELD_W) ? CMP_W : cbd_pkg::LEN_FIELD_W;

    localparam logic [CMP_W-1:0]  MIN_LEN  = CMP_W'(cbd_pkg::MIN_BLOCK_BYTES);
    localparam logic [CMP_W-1:0]  MAX_LEN  = CMP_W'(MAX_BLOCK_BYTES);
    localparam logic [CMP_W-1:0]  HDR_LEN  = CMP_W'(cbd_pkg::HEADER_BYTES);
    localparam logic [POS_W-1:0]  HDR_POS  = POS_W'(cbd_pkg::HEADER_BYTES);

    logic [POS_W-1:0]  byte_position_reg, byte_position_next;
    logic [15:0]       stored_checksum_reg, stored_checksum_next;
    logic [15:0]       length_and_flags_reg, length_and_flags_next;
    logic [15:0]       running_sum_reg, running_sum_next;
    logic [7:0]        pending_low_byte_reg, pending_low_byte_next;
    cbd_pkg::mode_t    run_mode_reg, run_mode_next;

    logic [CMP_W-1:0]  len_clamped;
    logic [CMP_W-1:0]  len_eff;
    logic [CMP_W-1:0]  pos_ext;
    logic [WIDE_W-1:0] plen;
    logic [WIDE_W-1:0] room;
    logic [WIDE_W-1:0] pay_offset;
    logic              bad_len;
    logic              pay;
    logic              closing;
    logic              final_flag;
    logic              active;
    cbd_pkg::status_t  close_status;

    // Effective block length: clamped to the legal range and made even.
    always_comb begin
        len_clamped = CMP_W'(block_length);
        if (len_clamped < MIN_LEN) begin
            len_clamped = MIN_LEN;
        end else if (len_clamped > MAX_LEN) begin
            len_clamped = MAX_LEN;
        end
        len_eff = {len_clamped[CMP_W-1:1], 1'b0};
    end

    assign active  = (run_mode_reg == cbd_pkg::MODE_ACTIVE);
    assign pos_ext = CMP_W'(byte_position_reg);

    // Header capture and the running sum of little-endian words from byte 2.
    always_comb begin
        stored_checksum_next  = stored_checksum_reg;
        length_and_flags_next = length_and_flags_reg;
        running_sum_next      = running_sum_reg;
        pending_low_byte_next = pending_low_byte_reg;
        priority if (byte_position_reg == POS_W'(0)) begin
            stored_checksum_next  = {8'd0, data_byte};
            length_and_flags_next = 16'd0;
            running_sum_next      = 16'd0;
        end else if (byte_position_reg == POS_W'(1)) begin
            stored_checksum_next[15:8] = data_byte;
        end else if (byte_position_reg == POS_W'(2)) begin
            length_and_flags_next = {8'd0, data_byte};
        end else if (byte_position_reg == POS_W'(3)) begin
            length_and_flags_next[15:8] = data_byte;
        end else begin
            length_and_flags_next = length_and_flags_reg;
        end
        if (byte_position_reg >= POS_W'(2)) begin
            if (!byte_position_reg[0]) begin
                pending_low_byte_next = data_byte;
            end else begin
                running_sum_next = running_sum_reg + {data_byte, pending_low_byte_reg};
            end
        end
    end

    // Length check, payload window and block close.
    always_comb begin
        plen       = WIDE_W'(length_and_flags_next[cbd_pkg::LEN_FIELD_W-1:0]);
        room       = WIDE_W'(len_eff - HDR_LEN);
        pay_offset = WIDE_W'(byte_position_reg - HDR_POS);
        bad_len    = plen > room;
        pay        = (byte_position_reg >= HDR_POS) && !bad_len && (pay_offset < plen);
        closing    = pos_ext >= (len_eff - CMP_W'(1));
        final_flag = length_and_flags_next[cbd_pkg::FINAL_FLAG_BIT];
        if (bad_len) begin
            close_status = cbd_pkg::STATUS_BAD_LEN;
        end else if (running_sum_next != stored_checksum_next) begin
            close_status = cbd_pkg::STATUS_MISMATCH;
        end else begin
            close_status = cbd_pkg::STATUS_OK;
        end
    end

    // Result of the accepted byte.
    always_comb begin
        result.payload_valid = pay;
        result.payload_byte  = pay ? data_byte : 8'd0;
        result.block_done    = closing || end_of_input;
        result.block_status  = closing ? close_status :
                               (end_of_input ? cbd_pkg::STATUS_PARTIAL : cbd_pkg::STATUS_OK);
        result.final_block   = (closing || end_of_input) ? final_flag : 1'b0;
        status.active        = active;
        status.result_valid  = accept && active && (pay || closing || end_of_input);
    end

    // Position and run state after the byte.
    always_comb begin
        byte_position_next = byte_position_reg + POS_W'(1);
        run_mode_next      = run_mode_reg;
        if (closing) begin
            byte_position_next = POS_W'(0);
            if (close_status != cbd_pkg::STATUS_OK) begin
                run_mode_next = cbd_pkg::MODE_FAILED;
            end else if (final_flag || end_of_input) begin
                run_mode_next = cbd_pkg::MODE_FINISHED;
            end
        end else if (end_of_input) begin
            byte_position_next = POS_W'(0);
            run_mode_next      = cbd_pkg::MODE_FAILED;
        end
    end

    // State registers; bytes are ignored once the run has stopped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg    <= '0;
            stored_checksum_reg  <= '0;
            length_and_flags_reg <= '0;
            running_sum_reg      <= '0;
            pending_low_byte_reg <= '0;
            run_mode_reg         <= cbd_pkg::MODE_ACTIVE;
        end else if (accept && active) begin
            byte_position_reg    <= byte_position_next;
            stored_checksum_reg  <= stored_checksum_next;
            length_and_flags_reg <= length_and_flags_next;
            running_sum_reg      <= running_sum_next;
            pending_low_byte_reg <= pending_low_byte_next;
            run_mode_reg         <= run_mode_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/cbd_out_queue.sv @@
// Two-entry result queue that decouples the input side from a stalled receiver.
// Depends on cbd_pkg.
`default_nettype none

module cbd_out_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire cbd_pkg::result_t push_data,
    output logic                  can_push,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cbd_pkg::result_t      out_data
);

    cbd_pkg::result_t entries_reg [2];
    logic [1:0]       count_reg, count_next;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic             pop;

    assign can_push  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Occupancy after this cycle's push and pop.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/checked_block_deframer_top.sv @@
// Top level of the checked block deframer: stream ports, APB port, assertions.
// Depends on cbd_pkg, cbd_apb_regs, cbd_core, cbd_out_queue and the assert header.
//
// Usage:
//   Input stream s_*: one deciphered byte per word in s_tdata[7:0]; s_tlast
//   marks the last byte of the whole image. Output stream m_*: at most one
//   word per input byte. m_tuser is high when m_tdata[7:0] carries a payload
//   byte; m_tlast is high when the word closes a block or the input, and then
//   m_tdata[9:8] holds the block status and m_tdata[10] the final block flag.
//   APB: register block_length at byte address 0; write it only while idle.
//   An accepted byte's result word is registered in the result queue.
//   Throughput: one byte per cycle while the queue has room, set by the
//   single pass from the accepted byte through the checksum add and length compare.
//   Reset clears the block position, header words and sum, restores a block
//   length of 1000 and empties the result queue. When the receiver stalls,
//   the two-entry result queue keeps taking bytes until both entries hold
//   results; s_tready then drops until a word is taken. After the final block,
//   an error, or the end of the input, bytes are taken and dropped until reset.
`default_nettype none
`include "checked_block_deframer_top_assert.svh"

module checked_block_deframer_top #(
    parameter int unsigned MAX_BLOCK_BYTES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_input
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [7:0] payload_byte, [9:8] block_status,
                                        // [10] final_block, [15:11] zero
    output logic             m_tuser,   // [0] payload_valid
    output logic             m_tlast,   // block_done
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [cbd_pkg::CFG_W-1:0] block_length;
    logic                      s_accept;
    logic                      can_push;
    cbd_pkg::result_t          core_result;
    cbd_pkg::core_status_t     core_status;
    cbd_pkg::result_t          out_result;

    assign s_tready = can_push;
    assign s_accept = s_tvalid && s_tready;

    cbd_apb_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .block_length (block_length)
    );

    cbd_core #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .data_byte    (s_tdata),
        .end_of_input (s_tlast),
        .block_length (block_length),
        .result       (core_result),
        .status       (core_status)
    );

    cbd_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (core_status.result_valid),
        .push_data (core_result),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // Output packing.
    assign m_tdata = {5'd0, out_result.final_block, out_result.block_status,
                      out_result.payload_byte};
    assign m_tuser = out_result.payload_valid;
    assign m_tlast = out_result.block_done;

    // A failed close stops the run.
    `CBD_ASSERT_NEXT(a_fail_stops, aclk, aresetn,
        core_status.result_valid && core_result.block_done &&
        (core_result.block_status != cbd_pkg::STATUS_OK),
        !core_status.active, "block error did not stop the deframer")

    // Status and flag are only carried by a word that closes a block.
    `CBD_ASSERT_IMPLIES(a_status_on_close, aclk, aresetn,
        m_tvalid && !m_tlast, (m_tdata[9:8] == 2'd0) && !m_tdata[10],
        "status or final flag on a word that closes no block")

    // A word without a payload byte carries a zero byte.
    `CBD_ASSERT_IMPLIES(a_zero_byte, aclk, aresetn,
        m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0,
        "nonzero byte on a word without payload")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the checked block deframer top level.
// Drives checksummed blocks into the byte stream and checks every result word
// against an internal predictor. Depends only on cbd_pkg and checked_block_deframer_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_BLK       = 1024;
    localparam int unsigned RESET_CYCLES  = 6;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned IDLE_PCT      = 25;
    localparam int unsigned QUIET_START   = 400;
    localparam int unsigned QUIET_END     = 1000;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned RANDOM_TARGET = 450;
    localparam int unsigned MAX_PRINT     = 100;
    localparam time         TIMEOUT_NS    = 2ms;

    // Value of the block length register.
    typedef logic [cbd_pkg::CFG_W-1:0] cfg_word_t;

    // How the image is brought to a stop at the end of the run.
    typedef enum int {
        END_FINAL,
        END_BAD_LEN,
        END_MISMATCH,
        END_PARTIAL,
        END_INPUT
    } ending_t;

    // One word of the input stream.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } in_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tlast  = 1'b0;    // end_of_input
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] payload_byte, [9:8] block_status,
                                     // [10] final_block
    logic        m_tuser;            // [0] payload_valid
    logic        m_tlast;            // block_done
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state, kept as the block keeps it.
    cfg_word_t        blk_len_reg   = cbd_pkg::BLOCK_LEN_RESET;
    int unsigned      blk_pos       = 0;
    logic [15:0]      hdr_cksum     = '0;
    logic [15:0]      hdr_lenw      = '0;
    logic [15:0]      word_sum      = '0;
    logic [7:0]       low_byte      = '0;
    cbd_pkg::mode_t   deframer_mode = cbd_pkg::MODE_ACTIVE;

    cbd_pkg::result_t expected_words[$];
    in_word_t         byte_q[$];
    logic [7:0]       frame[$];
    in_word_t         next_word;

    int unsigned mismatches     = 0;
    int unsigned words_checked  = 0;
    int unsigned items_queued   = 0;
    int unsigned settings_used  = 0;
    int unsigned cyc            = 0;
    int unsigned hold_left      = 0;
    logic        hold_req       = 1'b0;
    logic        hold_seen      = 1'b0;
    logic        quiet;
    ending_t     ending;

    checked_block_deframer_top #(
        .MAX_BLOCK_BYTES(MAX_BLK)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // Both sides stop idling inside one window of the run.
    assign quiet = (cyc >= QUIET_START) && (cyc < QUIET_END);

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINT) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Block length as the block applies it: clipped to range and made even.
    function automatic int unsigned eff_length(input cfg_word_t value);
        int unsigned v;
        v = value;
        if (v < cbd_pkg::MIN_BLOCK_BYTES) v = cbd_pkg::MIN_BLOCK_BYTES;
        if (v > MAX_BLK) v = MAX_BLK;
        return v & ~32'd1;
    endfunction

    // Predict the result word, if any, for one accepted byte.
    task automatic deframe_byte(input logic [7:0] b, input logic last);
        int unsigned      eff;
        int unsigned      plen;
        logic             pay;
        logic             closing;
        logic             bad_len;
        cbd_pkg::result_t r;
        if (deframer_mode != cbd_pkg::MODE_ACTIVE) return;
        eff = eff_length(blk_len_reg);
        case (blk_pos)
            0: begin
                hdr_cksum = {8'h00, b};
                hdr_lenw  = '0;
                word_sum  = '0;
            end
            1: hdr_cksum[15:8] = b;
            2: hdr_lenw = {8'h00, b};
            3: hdr_lenw[15:8] = b;
            default: ;
        endcase
        // The sum covers every little-endian word from byte 2 on.
        if (blk_pos >= 2) begin
            if (!blk_pos[0]) low_byte = b;
            else word_sum = word_sum + {b, low_byte};
        end
        plen    = hdr_lenw[cbd_pkg::LEN_FIELD_W-1:0];
        bad_len = plen > eff - cbd_pkg::HEADER_BYTES;
        pay     = blk_pos >= cbd_pkg::HEADER_BYTES && !bad_len &&
                  (blk_pos - cbd_pkg::HEADER_BYTES) < plen;
        closing = blk_pos >= eff - 1;
        r = '0;
        r.payload_valid = pay;
        r.payload_byte  = pay ? b : 8'h00;
        if (closing || last) begin
            r.block_done  = 1'b1;
            r.final_block = hdr_lenw[cbd_pkg::FINAL_FLAG_BIT];
            if (!closing) r.block_status = cbd_pkg::STATUS_PARTIAL;
            else if (bad_len) r.block_status = cbd_pkg::STATUS_BAD_LEN;
            else if (word_sum != hdr_cksum) r.block_status = cbd_pkg::STATUS_MISMATCH;
            else r.block_status = cbd_pkg::STATUS_OK;
            blk_pos = 0;
            if (r.block_status != cbd_pkg::STATUS_OK) begin
                deframer_mode = cbd_pkg::MODE_FAILED;
            end else if (hdr_lenw[cbd_pkg::FINAL_FLAG_BIT] || last) begin
                deframer_mode = cbd_pkg::MODE_FINISHED;
            end
            expected_words.push_back(r);
        end else begin
            blk_pos++;
            if (pay) expected_words.push_back(r);
        end
    endtask

    // Build one block up to close_pos with a correct checksum.
    task automatic build_frame(input int unsigned close_pos, input int unsigned plen,
                               input logic fin, input logic extreme);
        logic [15:0] lenw;
        logic [15:0] sum;
        int unsigned p;
        frame.delete();
        for (p = 0; p <= close_pos; p++) begin
            frame.push_back(extreme ? (p[0] ? 8'hff : 8'h00) : 8'($urandom));
        end
        lenw = {fin, 3'($urandom), 12'(plen)};
        frame[2] = lenw[7:0];
        frame[3] = lenw[15:8];
        sum = '0;
        for (p = 3; p <= close_pos; p += 2) begin
            sum = sum + {frame[p], frame[p-1]};
        end
        frame[0] = sum[7:0];
        frame[1] = sum[15:8];
    endtask

    // Hand a slice of the current block to the driver.
    task automatic queue_frame(input int unsigned first, input int unsigned last_idx,
                               input logic eoi);
        in_word_t    w;
        int unsigned p;
        for (p = first; p <= last_idx; p++) begin
            w.data = frame[p];
            w.last = eoi && (p == last_idx);
            byte_q.push_back(w);
            items_queued++;
        end
    endtask

    // Payload length for a well-formed block: often an extreme.
    function automatic int unsigned pick_plen(input int unsigned eff);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return eff - cbd_pkg::HEADER_BYTES;
            default: return $urandom_range(0, eff - cbd_pkg::HEADER_BYTES);
        endcase
    endfunction

    // Wait until every byte is taken and every result has come out.
    task automatic wait_idle();
        do @(posedge aclk);
        while (byte_q.size() != 0 || s_tvalid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB read of the block length register, checked against want.
    task automatic cfg_read_check(input cfg_word_t want);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= cbd_pkg::ADDR_BLOCK_LENGTH;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata !== 32'(want)) begin
            report_mismatch($sformatf("block_length read %0h, expected %0h", prdata, want));
        end
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB write of the block length register while the block is idle.
    task automatic cfg_write(input cfg_word_t value);
        wait_idle();
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= cbd_pkg::ADDR_BLOCK_LENGTH;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // The register takes the value at this edge.
        blk_len_reg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
        cfg_read_check(value);
    endtask

    // Field-by-field comparison of one accepted result word.
    task automatic check_word(input cbd_pkg::result_t want);
        words_checked++;
        if (m_tuser !== want.payload_valid) begin
            report_mismatch($sformatf("payload_valid %b, expected %b", m_tuser,
                                      want.payload_valid));
        end
        if (m_tdata[7:0] !== want.payload_byte) begin
            report_mismatch($sformatf("payload_byte %0h, expected %0h", m_tdata[7:0],
                                      want.payload_byte));
        end
        if (m_tlast !== want.block_done) begin
            report_mismatch($sformatf("block_done %b, expected %b", m_tlast, want.block_done));
        end
        if (m_tdata[9:8] !== want.block_status) begin
            report_mismatch($sformatf("block_status %0d, expected %0d", m_tdata[9:8],
                                      want.block_status));
        end
        if (m_tdata[10] !== want.final_block) begin
            report_mismatch($sformatf("final_block %b, expected %b", m_tdata[10],
                                      want.final_block));
        end
    endtask

    // Cycle count and the long receiver hold-off.
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Input driver: offers queued bytes with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid      <= 1'b0;
            s_tdata       <= 8'h00;
            s_tlast       <= 1'b0;
            blk_len_reg   = cbd_pkg::BLOCK_LEN_RESET;
            blk_pos       = 0;
            hdr_cksum     = '0;
            hdr_lenw      = '0;
            word_sum      = '0;
            low_byte      = '0;
            deframer_mode = cbd_pkg::MODE_ACTIVE;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (byte_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_word = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.data;
                    s_tlast  <= next_word.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each word against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("result word %0h with nothing pending", m_tdata));
                end else begin
                    check_word(expected_words.pop_front());
                end
            end
            m_tready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus: directed blocks, random blocks, one full-size block, then the stop.
    initial begin
        int unsigned eff;
        int unsigned nblk;
        int unsigned cut;
        cfg_word_t   reg_val;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        cfg_read_check(cbd_pkg::BLOCK_LEN_RESET);

        // Shortest blocks; a value below the minimum acts as the minimum.
        cfg_write(11'd0);
        build_frame(5, 0, 1'b0, 1'b0);
        queue_frame(0, 5, 1'b0);
        build_frame(5, 2, 1'b0, 1'b1);
        queue_frame(0, 5, 1'b0);

        // Odd length rounds down; shrinking mid-block closes it on the next byte.
        cfg_write(11'd21);
        build_frame(9, 2, 1'b0, 1'b0);
        queue_frame(0, 8, 1'b0);
        cfg_write(11'd7);
        queue_frame(9, 9, 1'b0);

        // Well-formed blocks under random block lengths.
        while (items_queued < RANDOM_TARGET) begin
            case ($urandom_range(0, 9))
                0: reg_val = cfg_word_t'($urandom_range(0, cbd_pkg::MIN_BLOCK_BYTES - 1));
                1, 2: reg_val = cfg_word_t'($urandom_range(3, 40) * 2 + 1);
                default: reg_val = cfg_word_t'($urandom_range(cbd_pkg::MIN_BLOCK_BYTES, 96));
            endcase
            cfg_write(reg_val);
            eff  = eff_length(reg_val);
            nblk = $urandom_range(1, 6);
            for (int unsigned k = 0; k < nblk && items_queued < RANDOM_TARGET; k++) begin
                build_frame(eff - 1, pick_plen(eff), 1'b0, 1'b0);
                queue_frame(0, eff - 1, 1'b0);
            end
        end

        // Largest block with a full payload, while the receiver holds off for a while.
        cfg_write({cbd_pkg::CFG_W{1'b1}});
        eff = eff_length({cbd_pkg::CFG_W{1'b1}});
        build_frame(eff - 1, eff - cbd_pkg::HEADER_BYTES, 1'b0, 1'b0);
        queue_frame(0, eff - 1, 1'b0);
        hold_req <= ~hold_req;

        // One way of stopping the image, then bytes that must be ignored.
        reg_val = cfg_word_t'($urandom_range(cbd_pkg::MIN_BLOCK_BYTES, 64));
        cfg_write(reg_val);
        eff    = eff_length(reg_val);
        ending = ending_t'($urandom_range(END_FINAL, END_INPUT));
        case (ending)
            END_FINAL: begin
                build_frame(eff - 1, pick_plen(eff), 1'b1, 1'b0);
                queue_frame(0, eff - 1, 1'($urandom));
            end
            END_BAD_LEN: begin
                build_frame(eff - 1, $urandom_range(eff - cbd_pkg::HEADER_BYTES + 1, 4095),
                            1'($urandom), 1'b0);
                // Bad length wins over a wrong checksum.
                if ($urandom_range(0, 1)) frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
                queue_frame(0, eff - 1, 1'b0);
            end
            END_MISMATCH: begin
                build_frame(eff - 1, pick_plen(eff), 1'($urandom), 1'b0);
                frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
                queue_frame(0, eff - 1, 1'b0);
            end
            END_PARTIAL: begin
                build_frame(eff - 1, pick_plen(eff), 1'($urandom), 1'b0);
                cut = $urandom_range(0, eff - 2);
                queue_frame(0, cut, 1'b1);
            end
            default: begin
                build_frame(eff - 1, pick_plen(eff), 1'b0, 1'b0);
                queue_frame(0, eff - 1, 1'b1);
            end
        endcase
        build_frame(5, $urandom_range(0, 2), 1'($urandom), 1'b0);
        queue_frame(0, 5, 1'($urandom));

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("Covered %0d bytes under %0d block length settings, %0d result words checked.",
                 items_queued, settings_used, words_checked);
        $display("The image was stopped by %s.", ending.name());
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog for a block that hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ checked_block_deframer_top.f @@
+incdir+hdl
hdl/cbd_pkg.sv
hdl/cbd_apb_regs.sv
hdl/cbd_core.sv
hdl/cbd_out_queue.sv
hdl/checked_block_deframer_top.sv
test/testbench.sv
